// File: hdl/bss_pkg.sv
// Shared types and constants of the broadcast step scheduler.
`default_nettype none
package bss_pkg;

    localparam int RANK_W = 6;   // width of a rank index
    localparam int COUNT_W = 7;  // width of the rank count register
    localparam int STEP_W = 4;   // width of a step index
    localparam int SLICE_W = 6;  // width of slice counts and slice indexes
    localparam int BIT_W = 3;    // indexes a bit of a rank
    localparam logic [SLICE_W-1:0] MAX_OUT = 6'd32;

    // configuration register indexes
    localparam logic [1:0] CFG_RANK_COUNT = 2'd0;
    localparam logic [1:0] CFG_MY_RANK = 2'd1;
    localparam logic [1:0] CFG_ROOT_RANK = 2'd2;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_RANGE = 2'd1,
        ST_STEPS = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_PLAN_A,
        S_PLAN_B,
        S_LOAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic take;
        logic mod_step;
        logic plan_a;
        logic plan_b;
        logic load_out;
        logic advance;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic mod_done;
        logic out_last;
    } t_stat;

endpackage
`default_nettype wire

// File: hdl/broadcast_step_schedule.sv
// Broadcast step scheduler top level: stream ports, config port, sequencer and datapath.
// A step word is accepted, then the remainder pass walks each bit of a rank index,
// then plan A, plan B and the result load run before the first result word is valid.
// A step gives 1 to 32 result words; no new step word is taken before its last one,
// which go out one result word per cycle while the output side is ready.
// Reset: synchronous, active low; registers return to 4 ranks, rank 0, root 0.
`default_nettype none
module broadcast_step_schedule
    import bss_pkg::*;
#(
    parameter int MAX_RANKS = 16,
    parameter int MAX_STEPS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [3:0] step_index, [7:4] zero
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [0] does_send, [1] does_receive, [7:2] send_peer, [13:8] receive_peer,
    // [19:14] send_slices, [25:20] receive_slices, [31:26] slice_number
    output logic [31:0]             m_axis_tdata,
    output logic [2:0]              m_axis_tuser,   // [1:0] status, [2] slice_valid
    output logic                    m_axis_tlast,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    logic [1:0]         w_status;
    logic               w_does_send;
    logic               w_does_receive;
    logic [RANK_W-1:0]  w_send_peer;
    logic [RANK_W-1:0]  w_receive_peer;
    logic [SLICE_W-1:0] w_send_slices;
    logic [SLICE_W-1:0] w_receive_slices;
    logic [SLICE_W-1:0] w_slice_number;
    logic               w_slice_valid;

    bss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bss_datapath #(
        .MAX_RANKS (MAX_RANKS),
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_step           (s_axis_tdata[STEP_W-1:0]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_status         (w_status),
        .o_does_send      (w_does_send),
        .o_does_receive   (w_does_receive),
        .o_send_peer      (w_send_peer),
        .o_receive_peer   (w_receive_peer),
        .o_send_slices    (w_send_slices),
        .o_receive_slices (w_receive_slices),
        .o_slice_number   (w_slice_number),
        .o_slice_valid    (w_slice_valid),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {w_slice_number, w_receive_slices, w_send_slices,
                           w_receive_peer, w_send_peer, w_does_receive, w_does_send};
    assign m_axis_tuser = {w_slice_valid, w_status};

endmodule
`default_nettype wire

// File: hdl/bss_ctrl.sv
// Sequencer of the broadcast step scheduler: remainder pass, planning, result walk.
`default_nettype none
module bss_ctrl
    import bss_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) begin
                    n_state = S_PLAN_A;
                end
            end
            S_PLAN_A: begin
                o_cmd.plan_a = 1'b1;
                n_state = S_PLAN_B;
            end
            S_PLAN_B: begin
                o_cmd.plan_b = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_out = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                o_cmd.emit = 1'b1;
                if (i_out_ready) begin
                    // drop back to idle once the final word of the step is taken
                    if (i_stat.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/bss_datapath.sv
// Datapath of the broadcast step scheduler: registers, remainders, plan and slice walk.
`default_nettype none
module bss_datapath
    import bss_pkg::*;
#(
    parameter int MAX_RANKS = 16,
    parameter int MAX_STEPS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    input  wire logic [STEP_W-1:0]  i_step,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata,
    output logic [1:0]              o_status,
    output logic                    o_does_send,
    output logic                    o_does_receive,
    output logic [RANK_W-1:0]       o_send_peer,
    output logic [RANK_W-1:0]       o_receive_peer,
    output logic [SLICE_W-1:0]      o_send_slices,
    output logic [SLICE_W-1:0]      o_receive_slices,
    output logic [SLICE_W-1:0]      o_slice_number,
    output logic                    o_slice_valid,
    output logic                    o_last
);

    localparam logic [COUNT_W-1:0] MAX_RANKS_V = COUNT_W'(MAX_RANKS);
    localparam logic [4:0] MAX_STEPS_V = 5'(MAX_STEPS);

    // one compare and subtract: valid for values below twice the modulus
    function automatic logic [7:0] f_wrap(input logic [7:0] v, input logic [COUNT_W-1:0] n);
        logic [7:0] n8;
        n8 = {1'b0, n};
        f_wrap = (v >= n8) ? v - n8 : v;
    endfunction

    // configuration
    logic [COUNT_W-1:0] r_n;
    logic [RANK_W-1:0]  r_my;
    logic [RANK_W-1:0]  r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 7'd4;
            r_my <= '0;
            r_root <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RANK_COUNT: r_n <= i_cfg_wdata;
                CFG_MY_RANK:    r_my <= i_cfg_wdata[RANK_W-1:0];
                CFG_ROOT_RANK:  r_root <= i_cfg_wdata[RANK_W-1:0];
                default: ;
            endcase
        end
    end

    // restoring remainder, one bit of each rank per cycle
    logic [STEP_W-1:0]  r_step;
    logic [BIT_W-1:0]   r_bit;
    logic [COUNT_W-1:0] r_me_rem;
    logic [COUNT_W-1:0] r_root_rem;
    logic [7:0]         n_me_part;
    logic [7:0]         n_root_part;

    assign n_me_part = f_wrap({r_me_rem, r_my[r_bit]}, r_n);
    assign n_root_part = f_wrap({r_root_rem, r_root[r_bit]}, r_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_cmd.take) begin
            r_bit <= BIT_W'(RANK_W - 1);
        end else if (i_cmd.mod_step) begin
            r_bit <= r_bit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_step <= i_step;
            r_me_rem <= '0;
            r_root_rem <= '0;
        end else if (i_cmd.mod_step) begin
            r_me_rem <= n_me_part[COUNT_W-1:0];
            r_root_rem <= n_root_part[COUNT_W-1:0];
        end
    end

    // first planning stage: step count, checks, distance, window
    logic [COUNT_W-1:0] n_nm1;
    logic [3:0]         n_steps;
    logic [4:0]         n_steps2;
    logic [4:0]         n_exp_ag;
    logic [2:0]         n_exp;
    logic [7:0]         n_delta;
    logic [7:0]         n_cnt;
    logic [7:0]         n_dist;
    logic               n_scatter;
    logic               n_pow2;
    logic               n_final_scatter;
    t_status            n_status;

    assign n_nm1 = r_n - 1'b1;

    always_comb begin
        n_steps = '0;
        for (int i = 0; i < COUNT_W; i++) begin
            if (n_nm1[i]) begin
                n_steps = 4'(i + 1);
            end
        end
    end

    assign n_steps2 = {n_steps, 1'b0};
    assign n_scatter = r_step < n_steps;
    // allgather walks the exponents downwards
    assign n_exp_ag = n_steps2 - 5'd1 - {1'b0, r_step};
    assign n_exp = n_scatter ? r_step[2:0] : n_exp_ag[2:0];
    assign n_delta = 8'd1 << n_exp;
    assign n_cnt = ({1'b0, n_nm1} + n_delta) >> ({1'b0, n_exp} + 4'd1);
    assign n_dist = f_wrap(8'({2'b00, r_root_rem[RANK_W-1:0]}) + {1'b0, r_n}
                           - {2'b00, r_me_rem[RANK_W-1:0]}, r_n);
    assign n_pow2 = (r_n & n_nm1) == '0;
    assign n_final_scatter = ({1'b0, r_step} + 5'd1) == {1'b0, n_steps};

    always_comb begin
        if (r_n == '0 || r_n > MAX_RANKS_V || n_steps2 > MAX_STEPS_V) begin
            n_status = ST_STEPS;
        end else if ({1'b0, r_step} >= n_steps2) begin
            n_status = ST_RANGE;
        end else begin
            n_status = ST_OK;
        end
    end

    t_status    r_status;
    logic       r_scatter;
    logic [7:0] r_delta;
    logic [7:0] r_cnt;
    logic [7:0] r_dist;
    logic [7:0] r_active;

    always_ff @(posedge i_clk) begin
        if (i_cmd.plan_a) begin
            r_status <= n_status;
            r_scatter <= n_scatter;
            r_delta <= n_delta;
            r_cnt <= n_cnt;
            r_dist <= n_dist;
            r_active <= (!n_pow2 && n_final_scatter) ? {1'b0, r_n} - n_delta : n_delta;
        end
    end

    // second planning stage: roles, peers, counts, slice walk origin
    logic [7:0]         n_up;
    logic [7:0]         n_down;
    logic [7:0]         n_stride;
    logic [SLICE_W-1:0] n_count;
    logic [RANK_W-1:0]  r_me;

    assign r_me = r_me_rem[RANK_W-1:0];
    assign n_up = f_wrap({2'b00, r_me} + r_delta, r_n);
    assign n_down = f_wrap({2'b00, r_me} + {1'b0, r_n} - r_delta, r_n);
    assign n_stride = f_wrap({r_delta[6:0], 1'b0}, r_n);
    assign n_count = (r_cnt > {2'b00, MAX_OUT}) ? MAX_OUT : r_cnt[SLICE_W-1:0];

    logic               r_snd;
    logic               r_rcv;
    logic [RANK_W-1:0]  r_speer;
    logic [RANK_W-1:0]  r_rpeer;
    logic [SLICE_W-1:0] r_scnt;
    logic [SLICE_W-1:0] r_rcnt;
    logic [RANK_W-1:0]  r_start;
    logic [RANK_W-1:0]  r_stride;

    always_ff @(posedge i_clk) begin
        if (i_cmd.plan_b) begin
            r_snd <= 1'b0;
            r_rcv <= 1'b0;
            r_speer <= '0;
            r_rpeer <= '0;
            r_scnt <= '0;
            r_rcnt <= '0;
            r_start <= '0;
            r_stride <= '0;
            if (r_status == ST_OK) begin
                if (!r_scatter) begin
                    r_snd <= 1'b1;
                    r_rcv <= 1'b1;
                    r_speer <= n_up[RANK_W-1:0];
                    r_rpeer <= n_down[RANK_W-1:0];
                    r_scnt <= n_count;
                    r_rcnt <= n_count;
                    r_start <= r_me;
                    r_stride <= n_stride[RANK_W-1:0];
                end else if (r_dist < r_active) begin
                    r_snd <= 1'b1;
                    r_speer <= n_down[RANK_W-1:0];
                    r_scnt <= n_count;
                    r_start <= n_down[RANK_W-1:0];
                    r_stride <= n_stride[RANK_W-1:0];
                end else if (r_dist >= r_delta && r_dist < r_active + r_delta) begin
                    r_rcv <= 1'b1;
                    r_rpeer <= n_up[RANK_W-1:0];
                    r_rcnt <= n_count;
                end
            end
        end
    end

    // result register and slice walk
    logic               r_slice_valid;
    logic [RANK_W-1:0]  r_idx;
    logic [SLICE_W-1:0] r_num;
    logic               r_last;
    logic               n_has_slice;
    logic [7:0]         n_next_idx;

    assign n_has_slice = r_snd && (r_scnt != '0);
    assign n_next_idx = f_wrap({2'b00, r_idx} + {1'b0, r_n} - {2'b00, r_stride}, r_n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_slice_valid <= n_has_slice;
            r_idx <= n_has_slice ? r_start : '0;
            r_num <= SLICE_W'(1);
            r_last <= !n_has_slice || (r_scnt == SLICE_W'(1));
        end else if (i_cmd.advance) begin
            r_idx <= n_next_idx[RANK_W-1:0];
            r_num <= r_num + 1'b1;
            r_last <= (r_num + 1'b1) == r_scnt;
        end
    end

    assign o_stat.mod_done = (r_bit == '0);
    assign o_stat.out_last = r_last;

    assign o_status = r_status;
    assign o_does_send = r_snd;
    assign o_does_receive = r_rcv;
    assign o_send_peer = r_speer;
    assign o_receive_peer = r_rpeer;
    assign o_send_slices = r_scnt;
    assign o_receive_slices = r_rcnt;
    assign o_slice_number = r_idx;
    assign o_slice_valid = r_slice_valid;
    assign o_last = r_last;

    a_rem_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.plan_a && r_n != '0) |-> (r_me_rem < r_n && r_root_rem < r_n))
        else $error("rank remainder not below rank count");

    a_slice_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_slice_valid) |-> ({1'b0, r_idx} < r_n))
        else $error("slice index beyond rank count");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_status != ST_OK) |-> (!r_snd && !r_rcv && r_last && !r_slice_valid))
        else $error("error answer is not a single empty word");

    a_last_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_slice_valid) |-> (r_num != '0 && r_last == (r_num == r_scnt)))
        else $error("last flag out of step with slice count");

endmodule
`default_nettype wire

// File: bench/tb_broadcast_step_schedule.sv
// Self-checking bench for the broadcast step scheduler: directed table, random phases, scoreboard.
module tb_broadcast_step_schedule;
    import bss_pkg::*;

    localparam int MAX_RANKS = 16;
    localparam int MAX_STEPS = 8;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_ITEMS = 105;
    localparam int PLAN_ROWS = 20;

    // one result word, fields as the block reports them
    typedef struct packed {
        t_status            status;
        logic               sends;
        logic               receives;
        logic [RANK_W-1:0]  send_peer;
        logic [RANK_W-1:0]  recv_peer;
        logic [SLICE_W-1:0] send_cnt;
        logic [SLICE_W-1:0] recv_cnt;
        logic [SLICE_W-1:0] slice_no;
        logic               slice_valid;
        logic               is_last;
    } sched_word_t;

    typedef struct {
        int                ranks;
        int                me;
        int                root;
        logic [STEP_W-1:0] stp;
        bit                typed;     // error answer written out below
        t_status           st;
    } plan_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;    // [3:0] step_index, [7:4] zero
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [0] does_send, [1] does_receive, [7:2] send_peer, [13:8] receive_peer,
    // [19:14] send_slices, [25:20] receive_slices, [31:26] slice_number
    logic [31:0]        m_axis_tdata;
    logic [2:0]         m_axis_tuser;         // [1:0] status, [2] slice_valid
    logic               m_axis_tlast;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_RANK_COUNT;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;

    sched_word_t sched_due[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          calm = 1'b0;
    logic [7:0]  ready_pat = 8'hA5;
    int          pat_age = 0;

    // register shadows, reset values
    int ranks_cfg = 4;
    int me_cfg = 0;
    int root_cfg = 0;

    plan_row_t plan_rows [PLAN_ROWS] = '{
        '{4, 0, 0, 4'd0, 1'b0, ST_OK},
        '{4, 0, 0, 4'd1, 1'b0, ST_OK},
        '{4, 0, 0, 4'd2, 1'b0, ST_OK},
        '{4, 0, 0, 4'd3, 1'b0, ST_OK},
        '{4, 0, 0, 4'd4, 1'b1, ST_RANGE},
        '{4, 0, 0, 4'd15, 1'b1, ST_RANGE},
        '{0, 0, 0, 4'd0, 1'b1, ST_STEPS},
        '{1, 0, 0, 4'd0, 1'b1, ST_RANGE},
        '{17, 3, 3, 4'd2, 1'b1, ST_STEPS},
        '{127, 63, 63, 4'd15, 1'b1, ST_STEPS},
        '{2, 1, 0, 4'd0, 1'b0, ST_OK},
        '{2, 1, 0, 4'd1, 1'b0, ST_OK},
        '{16, 0, 0, 4'd0, 1'b0, ST_OK},
        '{16, 0, 0, 4'd7, 1'b0, ST_OK},
        '{16, 63, 63, 4'd3, 1'b0, ST_OK},
        '{5, 2, 0, 4'd2, 1'b0, ST_OK},
        '{5, 2, 0, 4'd3, 1'b0, ST_OK},
        '{8, 4, 0, 4'd0, 1'b0, ST_OK},
        '{8, 7, 0, 4'd0, 1'b0, ST_OK},
        '{11, 63, 6, 4'd3, 1'b0, ST_OK}
    };

    broadcast_step_schedule #(
        .MAX_RANKS(MAX_RANKS),
        .MAX_STEPS(MAX_STEPS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // bit length of (ranks - 1)
    function automatic int count_steps(input int n);
        int v;
        int bits;
        v = n - 1;
        bits = 0;
        while (v != 0) begin
            bits++;
            v = v >> 1;
        end
        return bits;
    endfunction

    // append one expected word to the scoreboard
    function automatic void enqueue_word(input sched_word_t w);
        sched_due = {sched_due, w};
    endfunction

    // queue the words one step should produce under the current registers
    function automatic void schedule_step(input logic [STEP_W-1:0] stp);
        int n;
        int nsteps;
        int step;
        int me;
        int root;
        int root_dist;
        int delta;
        int cnt;
        int active;
        int e;
        int start;
        int stride;
        int idx;
        int scnt;
        sched_word_t w;
        n = ranks_cfg;
        step = stp;
        w = '0;
        w.is_last = 1'b1;
        if (n == 0 || n > MAX_RANKS || 2 * count_steps(n) > MAX_STEPS) begin
            w.status = ST_STEPS;
            enqueue_word(w);
            return;
        end
        nsteps = count_steps(n);
        if (step >= 2 * nsteps) begin
            w.status = ST_RANGE;
            enqueue_word(w);
            return;
        end
        me = me_cfg % n;
        root = root_cfg % n;
        start = 0;
        stride = 0;
        if (step < nsteps) begin
            // scatter: halve the slice count each step
            root_dist = (root + n - me) % n;
            delta = 1 << step;
            cnt = (n - 1 + delta) >> (step + 1);
            if (cnt > MAX_OUT) cnt = MAX_OUT;
            active = ((n & (n - 1)) != 0 && step + 1 == nsteps) ? n - delta : delta;
            if (root_dist < active) begin
                w.sends = 1'b1;
                start = (me + n - delta % n) % n;
                w.send_peer = start;
                w.send_cnt = cnt;
                stride = (1 << (step + 1)) % n;
            end else if (root_dist >= delta && root_dist < active + delta) begin
                w.receives = 1'b1;
                w.recv_peer = (me + delta) % n;
                w.recv_cnt = cnt;
            end
        end else begin
            // allgather: distances walked in reverse
            e = nsteps - 1 - (step - nsteps);
            delta = 1 << e;
            cnt = (n - 1 + delta) >> (e + 1);
            if (cnt > MAX_OUT) cnt = MAX_OUT;
            w.sends = 1'b1;
            w.receives = 1'b1;
            w.send_peer = (me + delta) % n;
            w.recv_peer = (me + n - delta % n) % n;
            w.send_cnt = cnt;
            w.recv_cnt = cnt;
            start = me;
            stride = (1 << (e + 1)) % n;
        end
        w.status = ST_OK;
        scnt = w.sends ? cnt : 0;
        if (scnt == 0) begin
            enqueue_word(w);
            return;
        end
        idx = start;
        for (int i = 0; i < scnt; i++) begin
            w.slice_no = idx;
            w.slice_valid = 1'b1;
            w.is_last = (i == scnt - 1);
            enqueue_word(w);
            idx = (idx + n - stride) % n;
        end
    endfunction

    // offer one step word, idling between bursts
    task automatic send_step(input logic [STEP_W-1:0] stp, input bit typed,
                             input t_status st);
        int gap;
        sched_word_t w;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = calm ? 0 : $urandom_range(1, 6);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(8 - STEP_W){1'b0}}, stp};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        if (typed) begin
            w = '0;
            w.status = st;
            w.is_last = 1'b1;
            enqueue_word(w);
        end else begin
            schedule_step(stp);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sched_due.size() != 0) @(posedge i_clk);
    endtask

    // write all three registers once the block has gone quiet
    task automatic apply_config(input int n, input int me, input int root);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_RANK_COUNT;
        i_cfg_wdata <= n[COUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_MY_RANK;
        i_cfg_wdata <= {1'b0, me[RANK_W-1:0]};
        @(posedge i_clk);
        i_cfg_index <= CFG_ROOT_RANK;
        i_cfg_wdata <= {1'b0, root[RANK_W-1:0]};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ranks_cfg = n & 127;
        me_cfg = me & 63;
        root_cfg = root & 63;
    endtask

    // receiver stalls follow a rotating pattern, reloaded now and then
    always @(posedge i_clk) begin
        if (pat_age == 23) begin
            pat_age <= 0;
            ready_pat <= 8'($urandom_range(0, 255)) | (8'd1 << $urandom_range(0, 7));
        end else begin
            pat_age <= pat_age + 1;
            ready_pat <= {ready_pat[0], ready_pat[7:1]};
        end
        m_axis_tready <= calm ? 1'b1 : ready_pat[0];
    end

    always @(posedge i_clk) begin : check_words
        sched_word_t got;
        sched_word_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tuser[1:0]);
            got.sends = m_axis_tdata[0];
            got.receives = m_axis_tdata[1];
            got.send_peer = m_axis_tdata[7:2];
            got.recv_peer = m_axis_tdata[13:8];
            got.send_cnt = m_axis_tdata[19:14];
            got.recv_cnt = m_axis_tdata[25:20];
            got.slice_no = m_axis_tdata[31:26];
            got.slice_valid = m_axis_tuser[2];
            got.is_last = m_axis_tlast;
            if (sched_due.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected word: tdata %h tuser %h tlast %b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end else begin
                want = sched_due.pop_front();
                if (got !== want) begin
                    if (mismatches < 10)
                        $display({"word mismatch (st snd rcv sp rp sc rc sl v l): ",
                                  "expected %0d %b %b %0d %0d %0d %0d %0d %b %b, ",
                                  "got %0d %b %b %0d %0d %0d %0d %0d %b %b"},
                                 want.status, want.sends, want.receives, want.send_peer,
                                 want.recv_peer, want.send_cnt, want.recv_cnt,
                                 want.slice_no, want.slice_valid, want.is_last,
                                 got.status, got.sends, got.receives, got.send_peer,
                                 got.recv_peer, got.send_cnt, got.recv_cnt,
                                 got.slice_no, got.slice_valid, got.is_last);
                    mismatches++;
                end
            end
        end
    end

    // end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int items;
        int n;
        int me;
        int root;
        int nsteps;
        int run;
        bit well_formed;
        logic [STEP_W-1:0] stp;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan_rows[r]) begin
            if (plan_rows[r].ranks != ranks_cfg || plan_rows[r].me != me_cfg ||
                plan_rows[r].root != root_cfg)
                apply_config(plan_rows[r].ranks, plan_rows[r].me, plan_rows[r].root);
            send_step(plan_rows[r].stp, plan_rows[r].typed, plan_rows[r].st);
        end

        items = 0;
        while (items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(0, 127);
            else
                n = $urandom_range(2, MAX_RANKS);
            // ranks at or beyond the count wrap round
            if ($urandom_range(0, 3) == 0 || n == 0) begin
                me = $urandom_range(0, 63);
                root = $urandom_range(0, 63);
            end else begin
                me = $urandom_range(0, n - 1);
                root = $urandom_range(0, n - 1);
            end
            apply_config(n, me, root);
            calm = ($urandom_range(0, 3) == 0);
            well_formed = (n >= 2 && n <= MAX_RANKS);
            nsteps = well_formed ? count_steps(n) : 0;
            run = $urandom_range(8, 20);
            repeat (run) begin
                if (!well_formed || $urandom_range(0, 7) == 0)
                    stp = $urandom_range(0, 15);
                else
                    stp = $urandom_range(0, 2 * nsteps - 1);
                send_step(stp, 1'b0, ST_OK);
                items++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && sched_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
